// ===== src/assert_macros.svh =====
// Assertion macros shared by the histogram RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QCH_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("histogram assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QCH_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("histogram assertion failed");

`endif

// ===== src/qch_pkg.sv =====
// Shared types and constants of the quality calibration histogram.
// No dependencies; used by the top level.
package qch_pkg;

  localparam int QUAL_W    = 7;
  localparam int OP_W      = 4;
  localparam int EQ_W      = 8;
  localparam int TOTAL_W   = 33;
  localparam int STATUS_W  = 2;

  // Mantissa in Q.30 and the number of fraction bits of the log.
  localparam int MANT_W    = 31;
  localparam int FRAC_BITS = 8;

  // 10*log10(2) in Q.16, rounded.
  localparam int LOG_SCALE_W = 18;
  localparam logic [LOG_SCALE_W-1:0] LOG_SCALE = 18'd197283;
  localparam int ROUND_SHIFT = 24;

  localparam logic [EQ_W-1:0] QUALITY_CAP = 8'd157;

  // CIGAR op codes.
  localparam logic [OP_W-1:0] OP_INS      = 4'd1;
  localparam logic [OP_W-1:0] OP_DEL      = 4'd2;
  localparam logic [OP_W-1:0] OP_SOFTCLIP = 4'd4;
  localparam logic [OP_W-1:0] OP_MATCH    = 4'd7;
  localparam logic [OP_W-1:0] OP_MISMATCH = 4'd8;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_READ   = 2'd0,
    STATUS_BAD_OP = 2'd1,
    STATUS_RANGE  = 2'd2
  } status_t;

endpackage

// ===== src/qch_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; instantiated by the histogram top level.
module qch_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 94,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/quality_calibration_histogram.sv =====
// Empirical base-quality calibration histogram, top level.
// Depends on qch_pkg, qch_ram and assert_macros.svh.
//
// Usage: an item is taken at a rising edge where start is high and busy is
// low. With action low the item counts one aligned base into the hit or miss
// counter of its quality bin; with action high it reads one bin. A result
// beat is shown for exactly one cycle with done high; it must be taken then,
// since the receiver has no way to hold it off.
// Flow: an error item (unknown op code, quality out of range) gives its beat
// in the cycle after it is taken and leaves the block ready. A deletion or
// soft clip is dropped and the block stays ready. A counted base keeps busy
// high for one cycle (bin read, then write back).
// A bin read takes the total and the miss count of the bin in a COUNT_WIDTH+1
// bit word; for each the log unit finds the top bit one shift a cycle, then
// runs eight squaring steps on one 31x31 multiplier, once for the total
// and once for the misses, and reuses the multiplier for the final scaling.
// A bin with no misses answers right after the bin read, with no log steps.
// Reset clears the sequencer and one valid flag per bin, so every bin reads
// as zero right after reset; the counter RAM itself is not cleared.
`include "assert_macros.svh"

module quality_calibration_histogram #(
  parameter int MAX_QUALITY = 93,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           action,
  input  logic [qch_pkg::QUAL_W-1:0]     base_quality,
  input  logic [qch_pkg::OP_W-1:0]       op_kind,
  input  logic [qch_pkg::QUAL_W-1:0]     bin_index,
  output logic                           done,
  output logic [qch_pkg::QUAL_W-1:0]     predicted_quality,
  output logic [qch_pkg::EQ_W-1:0]       empirical_quality,
  output logic [qch_pkg::TOTAL_W-1:0]    total_count,
  output logic [qch_pkg::STATUS_W-1:0]   status
);

  localparam int NUM_BINS = MAX_QUALITY + 1;
  localparam int ADDR_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int ROW_W    = 2 * COUNT_WIDTH;
  localparam int XW       = COUNT_WIDTH + 1;
  localparam int MW       = (XW > qch_pkg::MANT_W) ? XW : qch_pkg::MANT_W;
  localparam int SW       = $clog2(XW);
  localparam int LW       = SW + qch_pkg::FRAC_BITS;
  localparam int PW       = LW + qch_pkg::LOG_SCALE_W;
  localparam int SUM_W    = PW + 1;
  localparam int PROD_W   = 2 * qch_pkg::MANT_W;
  localparam int STEP_W   = $clog2(qch_pkg::FRAC_BITS);
  localparam int ALIGN    = MW - XW;
  localparam logic [8:0]        MAX_Q9    = 9'(MAX_QUALITY);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(qch_pkg::FRAC_BITS - 1);
  localparam logic [SW-1:0]     TOP_BIT   = SW'(XW - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_RD     = 6'b000010,
    ST_NORM   = 6'b000100,
    ST_SQUARE = 6'b001000,
    ST_SCALE  = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   done_next;
  logic [NUM_BINS-1:0] row_valid;

  // Datapath registers.
  logic [qch_pkg::QUAL_W-1:0]   echo, echo_next;
  logic [qch_pkg::QUAL_W-1:0]   pq_next;
  logic [qch_pkg::EQ_W-1:0]     eq_next;
  logic [qch_pkg::TOTAL_W-1:0]  tc_next;
  logic [qch_pkg::STATUS_W-1:0] st_next;
  logic [ADDR_W-1:0]            addr, addr_next;
  logic                         is_read, is_read_next;
  logic                         is_hit, is_hit_next;
  logic [XW-1:0]                total, total_next;
  logic [COUNT_WIDTH-1:0]       miss, miss_next;
  logic [MW-1:0]                norm, norm_next;
  logic [SW-1:0]                shift, shift_next;
  logic [qch_pkg::MANT_W-1:0]   m, m_next;
  logic [qch_pkg::FRAC_BITS-1:0] frac, frac_next;
  logic [STEP_W-1:0]            step, step_next;
  logic                         phase, phase_next;
  logic [LW-1:0]                lt, lt_next;
  logic [LW-1:0]                d, d_next;
  logic [PW-1:0]                prod, prod_next;

  // RAM and datapath nets.
  logic                     we;
  logic [ADDR_W-1:0]        raddr;
  logic [ROW_W-1:0]         ram_rdata, row, wdata;
  logic [COUNT_WIDTH-1:0]   hit_cnt, miss_cnt, hit_inc, miss_inc;
  logic [XW-1:0]            sum;
  logic                     bin_bad, qual_bad;
  logic [qch_pkg::MANT_W-1:0] mul_a, mul_b, m_sq;
  logic [PROD_W-1:0]        product;
  logic [qch_pkg::MANT_W:0] sq_hi;
  logic                     sq_bit;
  logic [qch_pkg::FRAC_BITS-1:0] frac_shift;
  logic [LW-1:0]            log_val;
  logic [SUM_W-1:0]         q_sum, q_full;
  logic [qch_pkg::EQ_W-1:0] q_capped;

  assign busy = (state != ST_IDLE);

  assign raddr    = ADDR_W'(action ? bin_index : base_quality);
  assign bin_bad  = 9'(bin_index) > MAX_Q9;
  assign qual_bad = 9'(base_quality) > MAX_Q9;

  // A bin that was never written since reset reads as zero.
  assign row      = row_valid[addr] ? ram_rdata : '0;
  assign hit_cnt  = row[ROW_W-1:COUNT_WIDTH];
  assign miss_cnt = row[COUNT_WIDTH-1:0];
  assign sum      = XW'(hit_cnt) + XW'(miss_cnt);
  assign hit_inc  = (&hit_cnt) ? hit_cnt : hit_cnt + 1'b1;
  assign miss_inc = (&miss_cnt) ? miss_cnt : miss_cnt + 1'b1;
  assign wdata    = is_hit ? {hit_inc, miss_cnt} : {hit_cnt, miss_inc};
  assign we       = (state == ST_RD) && !is_read;

  qch_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_BINS)
  ) u_counts (
    .clk  (clk),
    .we   (we),
    .waddr(addr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  // The one multiplier squares the mantissa, or scales the log difference.
  assign mul_a   = (state == ST_SCALE) ? qch_pkg::MANT_W'(d) : m;
  assign mul_b   = (state == ST_SCALE) ? qch_pkg::MANT_W'(qch_pkg::LOG_SCALE) : m;
  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

  // The square is truncated back to Q.30; a value of two or more is halved
  // and yields a one in the fraction.
  assign sq_hi      = product[PROD_W-1:qch_pkg::MANT_W-1];
  assign sq_bit     = sq_hi[qch_pkg::MANT_W];
  assign m_sq       = sq_bit ? sq_hi[qch_pkg::MANT_W:1] : sq_hi[qch_pkg::MANT_W-1:0];
  assign frac_shift = {frac[qch_pkg::FRAC_BITS-2:0], sq_bit};
  assign log_val    = {TOP_BIT - shift, frac_shift};

  assign q_sum    = SUM_W'(prod) + (SUM_W'(1) << (qch_pkg::ROUND_SHIFT - 1));
  assign q_full   = q_sum >> qch_pkg::ROUND_SHIFT;
  assign q_capped = (q_full > SUM_W'(qch_pkg::QUALITY_CAP)) ? qch_pkg::QUALITY_CAP
                                                           : qch_pkg::EQ_W'(q_full);

  always_comb begin
    state_next   = state;
    done_next    = 1'b0;
    echo_next    = echo;
    pq_next      = predicted_quality;
    eq_next      = empirical_quality;
    tc_next      = total_count;
    st_next      = status;
    addr_next    = addr;
    is_read_next = is_read;
    is_hit_next  = is_hit;
    total_next   = total;
    miss_next    = miss;
    norm_next    = norm;
    shift_next   = shift;
    m_next       = m;
    frac_next    = frac;
    step_next    = step;
    phase_next   = phase;
    lt_next      = lt;
    d_next       = d;
    prod_next    = prod;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          echo_next    = action ? bin_index : base_quality;
          addr_next    = raddr;
          is_read_next = action;
          is_hit_next  = (op_kind == qch_pkg::OP_MATCH);
          pq_next      = echo_next;
          eq_next      = '0;
          tc_next      = '0;
          if (action) begin
            if (bin_bad) begin
              done_next = 1'b1;
              st_next   = qch_pkg::STATUS_RANGE;
            end else begin
              state_next = ST_RD;
            end
          end else begin
            case (op_kind) inside
              qch_pkg::OP_DEL, qch_pkg::OP_SOFTCLIP: begin
              end
              qch_pkg::OP_INS, qch_pkg::OP_MATCH, qch_pkg::OP_MISMATCH: begin
                if (qual_bad) begin
                  done_next = 1'b1;
                  st_next   = qch_pkg::STATUS_RANGE;
                end else begin
                  state_next = ST_RD;
                end
              end
              default: begin
                done_next = 1'b1;
                st_next   = qch_pkg::STATUS_BAD_OP;
              end
            endcase
          end
        end
      end
      ST_RD: begin
        state_next = ST_IDLE;
        if (is_read) begin
          total_next = sum;
          miss_next  = miss_cnt;
          if (miss_cnt == '0) begin
            done_next = 1'b1;
            pq_next   = echo;
            eq_next   = qch_pkg::QUALITY_CAP;
            tc_next   = qch_pkg::TOTAL_W'(sum);
            st_next   = qch_pkg::STATUS_READ;
          end else begin
            norm_next  = MW'(sum) << ALIGN;
            shift_next = '0;
            phase_next = 1'b0;
            state_next = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (norm[MW-1]) begin
          m_next     = norm[MW-1 -: qch_pkg::MANT_W];
          frac_next  = '0;
          step_next  = '0;
          state_next = ST_SQUARE;
        end else begin
          norm_next  = norm << 1;
          shift_next = shift + 1'b1;
        end
      end
      ST_SQUARE: begin
        m_next    = m_sq;
        frac_next = frac_shift;
        step_next = step + 1'b1;
        if (step == LAST_STEP) begin
          if (!phase) begin
            lt_next    = log_val;
            norm_next  = MW'(XW'(miss)) << ALIGN;
            shift_next = '0;
            phase_next = 1'b1;
            state_next = ST_NORM;
          end else begin
            d_next     = (lt > log_val) ? lt - log_val : '0;
            state_next = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        prod_next  = PW'(product);
        state_next = ST_FIN;
      end
      ST_FIN: begin
        done_next  = 1'b1;
        pq_next    = echo;
        eq_next    = q_capped;
        tc_next    = qch_pkg::TOTAL_W'(total);
        st_next    = qch_pkg::STATUS_READ;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      row_valid <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (we) begin
        row_valid[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    echo              <= echo_next;
    predicted_quality <= pq_next;
    empirical_quality <= eq_next;
    total_count       <= tc_next;
    status            <= st_next;
    addr              <= addr_next;
    is_read           <= is_read_next;
    is_hit            <= is_hit_next;
    total             <= total_next;
    miss              <= miss_next;
    norm              <= norm_next;
    shift             <= shift_next;
    m                 <= m_next;
    frac              <= frac_next;
    step              <= step_next;
    phase             <= phase_next;
    lt                <= lt_next;
    d                 <= d_next;
    prod              <= prod_next;
  end

  // The squaring loop only ever sees a normalized mantissa in [1, 2).
  `QCH_ASSERT_IMP(a_mant_norm, clk, rst, state == ST_SQUARE, m[qch_pkg::MANT_W-1])
  // Error beats carry no count and no quality.
  `QCH_ASSERT_IMP(a_err_zero, clk, rst, done && status != qch_pkg::STATUS_READ, total_count == '0 && empirical_quality == '0)
  `QCH_ASSERT_IMP(a_eq_cap, clk, rst, done, empirical_quality <= qch_pkg::QUALITY_CAP)
  // After the write back of a counted base the block is idle and its bin is marked valid.
  `QCH_ASSERT_NXT(a_count_wb, clk, rst, state == ST_RD && !is_read, state == ST_IDLE && row_valid[addr])

endmodule

// ===== verif/quality_calibration_histogram_tb.sv =====
// Self-checking testbench for the quality calibration histogram.
// Drives count and read beats, predicts each result beat, and compares them.
// Depends on qch_pkg and the quality_calibration_histogram RTL.
module quality_calibration_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_QUAL     = 93;
  localparam int COUNT_W      = 32;
  localparam int NUM_BINS     = MAX_QUAL + 1;
  localparam int NUM_RANDOM   = 1525;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 150;
  localparam int CALM_FIRST   = 600;
  localparam int CALM_LAST    = 900;

  localparam logic ACT_COUNT = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef struct packed {
    logic                       action;
    logic [qch_pkg::QUAL_W-1:0] qual;
    logic [qch_pkg::OP_W-1:0]   op;
    logic [qch_pkg::QUAL_W-1:0] bin;
  } base_beat_t;

  typedef struct packed {
    logic [qch_pkg::QUAL_W-1:0]  pq;
    logic [qch_pkg::EQ_W-1:0]    eq;
    logic [qch_pkg::TOTAL_W-1:0] total;
    qch_pkg::status_t            st;
  } calib_beat_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         action = 1'b0;
  logic [qch_pkg::QUAL_W-1:0]   base_quality = '0;
  logic [qch_pkg::OP_W-1:0]     op_kind = '0;
  logic [qch_pkg::QUAL_W-1:0]   bin_index = '0;
  logic                         done;
  logic [qch_pkg::QUAL_W-1:0]   predicted_quality;
  logic [qch_pkg::EQ_W-1:0]     empirical_quality;
  logic [qch_pkg::TOTAL_W-1:0]  total_count;
  logic [qch_pkg::STATUS_W-1:0] status;

  base_beat_t  base_beats[$];
  calib_beat_t calib_expected[$];
  logic [COUNT_W-1:0] hit_tally[NUM_BINS];
  logic [COUNT_W-1:0] miss_tally[NUM_BINS];
  int issued_count = 0;
  int taken_count = 0;
  int cycle_count = 0;
  int error_count = 0;
  int total_beats = 0;

  quality_calibration_histogram #(
    .MAX_QUALITY(MAX_QUAL),
    .COUNT_WIDTH(COUNT_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .base_quality(base_quality),
    .op_kind(op_kind),
    .bin_index(bin_index),
    .done(done),
    .predicted_quality(predicted_quality),
    .empirical_quality(empirical_quality),
    .total_count(total_count),
    .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Log2 in Q.8: top bit index, then eight squaring steps on a Q.30 mantissa.
  function automatic logic [15:0] log2_q8(input logic [qch_pkg::TOTAL_W-1:0] x);
    int msb;
    logic [63:0] mant;
    logic [7:0] frac;
    msb = 0;
    for (int i = 0; i < qch_pkg::TOTAL_W; i++) begin
      if (x[i]) msb = i;
    end
    if (msb > 30) mant = 64'(x) >> (msb - 30);
    else mant = 64'(x) << (30 - msb);
    frac = '0;
    for (int i = 0; i < qch_pkg::FRAC_BITS; i++) begin
      mant = (mant * mant) >> 30;
      frac = {frac[6:0], 1'b0};
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        frac[0] = 1'b1;
      end
    end
    return {msb[7:0], frac};
  endfunction

  function automatic logic [qch_pkg::EQ_W-1:0] empirical_q(
      input logic [qch_pkg::TOTAL_W-1:0] miss,
      input logic [qch_pkg::TOTAL_W-1:0] total);
    logic [15:0] lt;
    logic [15:0] lm;
    logic [63:0] diff;
    logic [63:0] q;
    if (miss == 0 || total == 0) return qch_pkg::QUALITY_CAP;
    lt = log2_q8(total);
    lm = log2_q8(miss);
    diff = (lt > lm) ? 64'(lt - lm) : 64'd0;
    q = (diff * 64'(qch_pkg::LOG_SCALE) + (64'd1 << (qch_pkg::ROUND_SHIFT - 1)))
        >> qch_pkg::ROUND_SHIFT;
    return (q > 64'(qch_pkg::QUALITY_CAP)) ? qch_pkg::QUALITY_CAP : q[qch_pkg::EQ_W-1:0];
  endfunction

  // Applies one beat to the histogram copy; returns 1 when it yields a result.
  function automatic bit tally_base(input base_beat_t b, output calib_beat_t r);
    logic [qch_pkg::TOTAL_W-1:0] total;
    r = '{pq: b.qual, eq: '0, total: '0, st: qch_pkg::STATUS_RANGE};
    if (b.action == ACT_READ) begin
      r.pq = b.bin;
      if (b.bin <= MAX_QUAL) begin
        total = qch_pkg::TOTAL_W'(hit_tally[b.bin]) + qch_pkg::TOTAL_W'(miss_tally[b.bin]);
        r.eq = empirical_q(qch_pkg::TOTAL_W'(miss_tally[b.bin]), total);
        r.total = total;
        r.st = qch_pkg::STATUS_READ;
      end
      return 1'b1;
    end
    if (b.op == qch_pkg::OP_DEL || b.op == qch_pkg::OP_SOFTCLIP) return 1'b0;
    if (b.op != qch_pkg::OP_INS && b.op != qch_pkg::OP_MATCH &&
        b.op != qch_pkg::OP_MISMATCH) begin
      r.st = qch_pkg::STATUS_BAD_OP;
      return 1'b1;
    end
    if (b.qual > MAX_QUAL) return 1'b1;
    if (b.op == qch_pkg::OP_MATCH) begin
      if (hit_tally[b.qual] != '1) hit_tally[b.qual] = hit_tally[b.qual] + 1'b1;
    end else begin
      if (miss_tally[b.qual] != '1) miss_tally[b.qual] = miss_tally[b.qual] + 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic add_beat(input logic act, input int qual, input int op, input int bin);
    base_beats.push_back('{action: act, qual: qch_pkg::QUAL_W'(qual),
                           op: qch_pkg::OP_W'(op), bin: qch_pkg::QUAL_W'(bin)});
  endtask

  // Driver: a new beat goes out only once the previous one has been taken.
  always @(negedge clk) begin
    base_beat_t b;
    if (rst) begin
      start <= 1'b0;
    end else if (issued_count == taken_count) begin
      if (base_beats.size() == 0 ||
          (!(issued_count >= CALM_FIRST && issued_count < CALM_LAST) &&
           $urandom_range(0, 99) < 15)) begin
        start <= 1'b0;
        action <= 1'($urandom);
        base_quality <= qch_pkg::QUAL_W'($urandom);
        op_kind <= qch_pkg::OP_W'($urandom);
        bin_index <= qch_pkg::QUAL_W'($urandom);
      end else begin
        b = base_beats.pop_front();
        start <= 1'b1;
        action <= b.action;
        base_quality <= b.qual;
        op_kind <= b.op;
        bin_index <= b.bin;
        issued_count <= issued_count + 1;
      end
    end
  end

  // Monitor: checks result beats and records every beat taken by the block.
  always @(posedge clk) begin
    base_beat_t b;
    calib_beat_t got;
    calib_beat_t want;
    calib_beat_t pred;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (!rst) begin
      if (done) begin
        got = '{pq: predicted_quality, eq: empirical_quality, total: total_count,
                st: qch_pkg::status_t'(status)};
        if (calib_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat pq=%0d status=%0d",
                                    got.pq, got.st));
        end else begin
          want = calib_expected.pop_front();
          if (got.pq != want.pq)
            report_mismatch($sformatf("predicted_quality %0d, want %0d", got.pq, want.pq));
          if (got.eq != want.eq)
            report_mismatch($sformatf("empirical_quality %0d, want %0d (bin %0d)",
                                      got.eq, want.eq, want.pq));
          if (got.total != want.total)
            report_mismatch($sformatf("total_count %0d, want %0d (bin %0d)",
                                      got.total, want.total, want.pq));
          if (got.st != want.st)
            report_mismatch($sformatf("status %0d, want %0d (pq %0d)",
                                      got.st, want.st, want.pq));
        end
      end
      if (start && !busy) begin
        b = '{action: action, qual: base_quality, op: op_kind, bin: bin_index};
        if (tally_base(b, pred)) calib_expected.push_back(pred);
        taken_count <= taken_count + 1;
      end
    end
  end

  initial begin
    int q;
    int sel;
    for (int i = 0; i < NUM_BINS; i++) begin
      hit_tally[i] = '0;
      miss_tally[i] = '0;
    end

    // Empty bins at both ends, and reads past the last bin.
    add_beat(ACT_READ, 0, 0, 0);
    add_beat(ACT_READ, 0, 0, MAX_QUAL);
    add_beat(ACT_READ, 0, 0, MAX_QUAL + 1);
    add_beat(ACT_READ, 127, 15, 127);
    // Every op code on one bin; unsupported codes give an error beat.
    for (int op = 0; op < 16; op++) add_beat(ACT_COUNT, 5, op, 0);
    // Quality out of range, except where the op ignores the quality.
    add_beat(ACT_COUNT, 127, qch_pkg::OP_INS, 0);
    add_beat(ACT_COUNT, MAX_QUAL + 1, qch_pkg::OP_MATCH, 0);
    add_beat(ACT_COUNT, 127, qch_pkg::OP_DEL, 0);
    add_beat(ACT_COUNT, 127, qch_pkg::OP_SOFTCLIP, 0);
    add_beat(ACT_COUNT, MAX_QUAL, qch_pkg::OP_MATCH, 0);
    add_beat(ACT_READ, 0, 0, 5);
    add_beat(ACT_READ, 0, 0, MAX_QUAL);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        if ($urandom_range(0, 9) == 0) q = $urandom_range(MAX_QUAL + 1, 127);
        else if ($urandom_range(0, 9) < 7) q = $urandom_range(0, 15);
        else q = $urandom_range(0, MAX_QUAL);
        add_beat(ACT_READ, $urandom_range(0, 127), $urandom_range(0, 15), q);
      end else if (sel < 28) begin
        add_beat(ACT_COUNT, $urandom_range(0, 127), $urandom_range(0, 15),
                 $urandom_range(0, 127));
      end else begin
        // Low bins get most counts; the miss rate falls with the bin so that
        // the empirical quality spans a useful range.
        q = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 15) : $urandom_range(0, MAX_QUAL);
        if ($urandom_range(0, q * q + 1) == 0)
          add_beat(ACT_COUNT, q,
                   $urandom_range(0, 1) ? qch_pkg::OP_INS : qch_pkg::OP_MISMATCH,
                   $urandom_range(0, 127));
        else if ($urandom_range(0, 19) == 0)
          add_beat(ACT_COUNT, q,
                   $urandom_range(0, 1) ? qch_pkg::OP_DEL : qch_pkg::OP_SOFTCLIP,
                   $urandom_range(0, 127));
        else
          add_beat(ACT_COUNT, q, qch_pkg::OP_MATCH, $urandom_range(0, 127));
      end
    end
    total_beats = base_beats.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (taken_count != total_beats || calib_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
